/* rtl/core/tlg_pkg.sv */
// ----------------------------------------------------------------------------
// tlg_pkg
// Shared constants, types and helper functions of the toroidal life grid
// engine.
// ----------------------------------------------------------------------------
package tlg_pkg;

    // Grid geometry.
    localparam int MAX_ROWS = 128;
    localparam int MAX_COLS = 128;
    localparam int ROW_W    = $clog2(MAX_ROWS);
    localparam int COL_W    = $clog2(MAX_COLS);
    localparam int NR_W     = ROW_W + 1;
    localparam int NC_W     = COL_W + 1;
    localparam int CELLS    = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W   = $clog2(CELLS);

    // Request fields and configuration.
    localparam int OP_W     = 3;
    localparam int RAD_W    = 6;
    localparam int SIDE_W   = RAD_W + 1;
    localparam int CFG_W    = 8;
    localparam int CFG_IDX_W = 1;

    // Reset values of the configuration registers.
    localparam logic [CFG_W-1:0] ROWS_RESET = CFG_W'(51);
    localparam logic [CFG_W-1:0] COLS_RESET = CFG_W'(51);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_ROWS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_COLS = 1'b1;

    // Reciprocal of three for the brush limit: floor(x/3) = (x*683) >> 11.
    localparam int RECIP3       = 683;
    localparam int RECIP3_SHIFT = 11;
    localparam int RECIP3_W     = 10;

    // Operation codes.
    typedef enum logic [OP_W-1:0] {
        OP_WRITE = 3'd0,
        OP_READ  = 3'd1,
        OP_PAINT = 3'd2,
        OP_CLEAR = 3'd3,
        OP_STEP  = 3'd4
    } op_t;

    // One port of requests into a single-bit grid memory.
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic              wdata;
        logic [ADDR_W-1:0] raddr;
    } ram_req_t;

    // Linear address of a cell.
    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
                                                     input logic [COL_W-1:0] c);
        logic [ADDR_W-1:0] base;
        base = ADDR_W'(r) * ADDR_W'(MAX_COLS);
        return base + ADDR_W'(c);
    endfunction

    // Wrapped row and column neighbors.
    function automatic logic [ROW_W-1:0] row_inc(input logic [ROW_W-1:0] r,
                                                  input logic [NR_W-1:0] n);
        return (NR_W'(r) == n - NR_W'(1)) ? '0 : r + ROW_W'(1);
    endfunction

    function automatic logic [ROW_W-1:0] row_dec(input logic [ROW_W-1:0] r,
                                                  input logic [NR_W-1:0] n);
        return (r == '0) ? ROW_W'(n - NR_W'(1)) : r - ROW_W'(1);
    endfunction

    function automatic logic [COL_W-1:0] col_inc(input logic [COL_W-1:0] c,
                                                  input logic [NC_W-1:0] n);
        return (NC_W'(c) == n - NC_W'(1)) ? '0 : c + COL_W'(1);
    endfunction

    function automatic logic [COL_W-1:0] col_dec(input logic [COL_W-1:0] c,
                                                  input logic [NC_W-1:0] n);
        return (c == '0) ? COL_W'(n - NC_W'(1)) : c - COL_W'(1);
    endfunction

endpackage

/* rtl/core/toroidal_life_grid_engine.sv */
// ----------------------------------------------------------------------------
// toroidal_life_grid_engine
// Wrap-around Game of Life grid (B3/S23) with cell access and painting.
// ----------------------------------------------------------------------------
// Usage: one request on the input channel (opcode, row_index, col_index,
// cell_value, brush_radius) gives one result (read_value, op_done) on the
// output channel. Both channels use valid/stall; a request is taken when
// in_valid is high and in_stall is low. One request is in work at a time.
// Work done per request from acceptance to result valid:
//   write or read: one access to the addressed cell; ignored request: none;
//   paint: a walk back to the corner, then a (2*radius+1)^2 square of writes,
//   radius after saturation; clear: all 16384 cells, one cell per cycle;
//   step: each cell takes nine reads of the
//   single read port of the grid memory plus a write to the scratch grid,
//   then a copy pass moves the scratch grid back.
// After reset a clearing pass empties all 16384 cells of the grid; in_stall is
// high during it. Configuration writes (cfg_we) are taken at any time, but
// are meant to land only while the block is idle.
// A finished result waits in an output register while out_stall is high;
// the next request is still accepted meanwhile.
// ----------------------------------------------------------------------------
module toroidal_life_grid_engine (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [tlg_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tlg_pkg::CFG_W-1:0]       cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [tlg_pkg::OP_W-1:0]        opcode,
    input  logic [tlg_pkg::ROW_W-1:0]       row_index,
    input  logic [tlg_pkg::COL_W-1:0]       col_index,
    input  logic                            cell_value,
    input  logic [tlg_pkg::RAD_W-1:0]       brush_radius,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            read_value,
    output logic                            op_done
);

    logic [tlg_pkg::CFG_W-1:0] rows_reg;
    logic [tlg_pkg::CFG_W-1:0] cols_reg;
    logic [tlg_pkg::NR_W-1:0]  nr;
    logic [tlg_pkg::NC_W-1:0]  nc;
    tlg_pkg::ram_req_t         cur_req;
    tlg_pkg::ram_req_t         nxt_req;
    logic                      cur_rdata;
    logic                      nxt_rdata;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg <= tlg_pkg::ROWS_RESET;
            cols_reg <= tlg_pkg::COLS_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                tlg_pkg::REG_ROWS: rows_reg <= cfg_data;
                tlg_pkg::REG_COLS: cols_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Effective grid size, clamped to the memory geometry.
    always_comb
    begin
        if (rows_reg == '0)
            nr = tlg_pkg::NR_W'(1);
        else if (32'(rows_reg) > tlg_pkg::MAX_ROWS)
            nr = tlg_pkg::NR_W'(tlg_pkg::MAX_ROWS);
        else
            nr = tlg_pkg::NR_W'(rows_reg);
        if (cols_reg == '0)
            nc = tlg_pkg::NC_W'(1);
        else if (32'(cols_reg) > tlg_pkg::MAX_COLS)
            nc = tlg_pkg::NC_W'(tlg_pkg::MAX_COLS);
        else
            nc = tlg_pkg::NC_W'(cols_reg);
    end

    tlg_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .opcode       (opcode),
        .row_index    (row_index),
        .col_index    (col_index),
        .cell_value   (cell_value),
        .brush_radius (brush_radius),
        .nr           (nr),
        .nc           (nc),
        .cur_req      (cur_req),
        .cur_rdata    (cur_rdata),
        .nxt_req      (nxt_req),
        .nxt_rdata    (nxt_rdata),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .read_value   (read_value),
        .op_done      (op_done)
    );

    // Live grid.
    tlg_ram #(
        .WIDTH (1),
        .DEPTH (tlg_pkg::CELLS)
    ) u_cur_ram (
        .clk   (clk),
        .we    (cur_req.we),
        .waddr (cur_req.waddr),
        .wdata (cur_req.wdata),
        .raddr (cur_req.raddr),
        .rdata (cur_rdata)
    );

    // Scratch grid for the next generation.
    tlg_ram #(
        .WIDTH (1),
        .DEPTH (tlg_pkg::CELLS)
    ) u_nxt_ram (
        .clk   (clk),
        .we    (nxt_req.we),
        .waddr (nxt_req.waddr),
        .wdata (nxt_req.wdata),
        .raddr (nxt_req.raddr),
        .rdata (nxt_rdata)
    );

endmodule

/* rtl/core/tlg_ram.sv */
// ----------------------------------------------------------------------------
// tlg_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module tlg_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 16384
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/core/tlg_ctrl.sv */
// ----------------------------------------------------------------------------
// tlg_ctrl
// Request sequencer: decodes each request and walks the grid memories for
// cell access, painting, clearing and generation steps.
// ----------------------------------------------------------------------------
module tlg_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [tlg_pkg::OP_W-1:0]      opcode,
    input  logic [tlg_pkg::ROW_W-1:0]     row_index,
    input  logic [tlg_pkg::COL_W-1:0]     col_index,
    input  logic                          cell_value,
    input  logic [tlg_pkg::RAD_W-1:0]     brush_radius,
    input  logic [tlg_pkg::NR_W-1:0]      nr,
    input  logic [tlg_pkg::NC_W-1:0]      nc,
    output tlg_pkg::ram_req_t             cur_req,
    input  logic                          cur_rdata,
    output tlg_pkg::ram_req_t             nxt_req,
    input  logic                          nxt_rdata,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          read_value,
    output logic                          op_done
);

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_READ, S_PBACK, S_PAINT, S_CLEAR,
        S_STEP, S_COPY, S_COPY_LAST, S_DONE
    } state_t;

    localparam logic [tlg_pkg::ADDR_W-1:0] LAST_ADDR = tlg_pkg::ADDR_W'(tlg_pkg::CELLS - 1);
    localparam int PROD_W = tlg_pkg::NR_W + tlg_pkg::RECIP3_W;

    state_t                        state_reg, state_next;
    logic [tlg_pkg::ROW_W-1:0]     r_reg, r_next;
    logic [tlg_pkg::COL_W-1:0]     c_reg, c_next;
    logic [tlg_pkg::COL_W-1:0]     c0_reg, c0_next;
    logic                          v_reg, v_next;
    logic [tlg_pkg::RAD_W-1:0]     rad_reg, rad_next;
    logic [tlg_pkg::RAD_W-1:0]     cnt_reg, cnt_next;
    logic [tlg_pkg::SIDE_W-1:0]    i_reg, i_next;
    logic [tlg_pkg::SIDE_W-1:0]    j_reg, j_next;
    logic [tlg_pkg::ADDR_W-1:0]    addr_reg, addr_next;
    logic [tlg_pkg::ADDR_W-1:0]    paddr_reg, paddr_next;
    logic                          pend_reg, pend_next;
    logic [3:0]                    k_reg, k_next;
    logic [3:0]                    sum_reg, sum_next;
    logic                          center_reg, center_next;
    logic                          res_rv_reg, res_rv_next;
    logic                          res_done_reg, res_done_next;
    logic                          out_valid_reg, out_valid_next;
    logic                          read_value_reg, read_value_next;
    logic                          op_done_reg, op_done_next;

    logic                          in_grid;
    logic [PROD_W-1:0]             lim_prod;
    logic [tlg_pkg::NR_W-1:0]      lim;
    logic [tlg_pkg::RAD_W-1:0]     rad_sat;
    logic [tlg_pkg::ROW_W-1:0]     rm, rp, nb_r;
    logic [tlg_pkg::COL_W-1:0]     cm, cp, nb_c;
    logic [3:0]                    total;
    logic                          last_row, last_col;

    // Request decode helpers.
    assign in_grid  = ({1'b0, row_index} < nr) && ({1'b0, col_index} < nc);
    assign lim_prod = PROD_W'(nr) * PROD_W'(tlg_pkg::RECIP3);
    assign lim      = tlg_pkg::NR_W'(lim_prod >> tlg_pkg::RECIP3_SHIFT);
    assign rad_sat  = ({{(tlg_pkg::NR_W > tlg_pkg::RAD_W ? tlg_pkg::NR_W - tlg_pkg::RAD_W : 1)
                        {1'b0}}, brush_radius} > lim) ? tlg_pkg::RAD_W'(lim) : brush_radius;

    // Wrapped neighbor coordinates of the cell under update.
    assign rm       = tlg_pkg::row_dec(r_reg, nr);
    assign rp       = tlg_pkg::row_inc(r_reg, nr);
    assign cm       = tlg_pkg::col_dec(c_reg, nc);
    assign cp       = tlg_pkg::col_inc(c_reg, nc);
    assign total    = sum_reg + 4'(cur_rdata);
    assign last_row = (tlg_pkg::NR_W'(r_reg) == nr - tlg_pkg::NR_W'(1));
    assign last_col = (tlg_pkg::NC_W'(c_reg) == nc - tlg_pkg::NC_W'(1));

    // Neighbor select for the read issued in this cycle.
    always_comb
    begin
        unique case (k_reg)
            4'd0:    begin nb_r = rm;    nb_c = cm;    end
            4'd1:    begin nb_r = rm;    nb_c = c_reg; end
            4'd2:    begin nb_r = rm;    nb_c = cp;    end
            4'd3:    begin nb_r = r_reg; nb_c = cm;    end
            4'd4:    begin nb_r = r_reg; nb_c = c_reg; end
            4'd5:    begin nb_r = r_reg; nb_c = cp;    end
            4'd6:    begin nb_r = rp;    nb_c = cm;    end
            4'd7:    begin nb_r = rp;    nb_c = c_reg; end
            4'd8:    begin nb_r = rp;    nb_c = cp;    end
            default: begin nb_r = r_reg; nb_c = c_reg; end
        endcase
    end

    // Sequencer next state.
    always_comb
    begin
        state_next      = state_reg;
        r_next          = r_reg;
        c_next          = c_reg;
        c0_next         = c0_reg;
        v_next          = v_reg;
        rad_next        = rad_reg;
        cnt_next        = cnt_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        addr_next       = addr_reg;
        paddr_next      = paddr_reg;
        pend_next       = pend_reg;
        k_next          = k_reg;
        sum_next        = sum_reg;
        center_next     = center_reg;
        res_rv_next     = res_rv_reg;
        res_done_next   = res_done_reg;
        out_valid_next  = out_valid_reg;
        read_value_next = read_value_reg;
        op_done_next    = op_done_reg;
        cur_req         = '0;
        nxt_req         = '0;
        in_stall        = (state_reg != S_IDLE);

        // The result register empties when the receiver takes it.
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_INIT, S_CLEAR:
            begin
                cur_req.we    = 1'b1;
                cur_req.waddr = addr_reg;
                cur_req.wdata = 1'b0;
                addr_next     = addr_reg + tlg_pkg::ADDR_W'(1);
                if (addr_reg == LAST_ADDR)
                begin
                    res_done_next = 1'b1;
                    state_next    = (state_reg == S_INIT) ? S_IDLE : S_DONE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    r_next        = row_index;
                    c_next        = col_index;
                    v_next        = cell_value;
                    res_rv_next   = 1'b0;
                    res_done_next = 1'b0;
                    state_next    = S_DONE;
                    case (opcode)
                        tlg_pkg::OP_WRITE:
                        begin
                            if (in_grid)
                            begin
                                cur_req.we    = 1'b1;
                                cur_req.waddr = tlg_pkg::cell_addr(row_index, col_index);
                                cur_req.wdata = cell_value;
                                res_done_next = 1'b1;
                            end
                        end
                        tlg_pkg::OP_READ:
                        begin
                            if (in_grid)
                            begin
                                cur_req.raddr = tlg_pkg::cell_addr(row_index, col_index);
                                state_next    = S_READ;
                            end
                        end
                        tlg_pkg::OP_PAINT:
                        begin
                            if (in_grid)
                            begin
                                cnt_next   = rad_sat;
                                rad_next   = rad_sat;
                                state_next = S_PBACK;
                            end
                        end
                        tlg_pkg::OP_CLEAR:
                        begin
                            addr_next  = '0;
                            state_next = S_CLEAR;
                        end
                        tlg_pkg::OP_STEP:
                        begin
                            r_next     = '0;
                            c_next     = '0;
                            k_next     = '0;
                            sum_next   = '0;
                            state_next = S_STEP;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                res_rv_next   = cur_rdata;
                res_done_next = 1'b1;
                state_next    = S_DONE;
            end
            S_PBACK:
            begin
                // Move to the top-left corner of the square, one step a cycle.
                if (cnt_reg != '0)
                begin
                    r_next   = tlg_pkg::row_dec(r_reg, nr);
                    c_next   = tlg_pkg::col_dec(c_reg, nc);
                    cnt_next = cnt_reg - tlg_pkg::RAD_W'(1);
                end
                else
                begin
                    c0_next    = c_reg;
                    i_next     = '0;
                    j_next     = '0;
                    state_next = S_PAINT;
                end
            end
            S_PAINT:
            begin
                cur_req.we    = 1'b1;
                cur_req.waddr = tlg_pkg::cell_addr(r_reg, c_reg);
                cur_req.wdata = v_reg;
                if (j_reg == {rad_reg, 1'b0})
                begin
                    j_next = '0;
                    c_next = c0_reg;
                    r_next = tlg_pkg::row_inc(r_reg, nr);
                    if (i_reg == {rad_reg, 1'b0})
                    begin
                        res_done_next = 1'b1;
                        state_next    = S_DONE;
                    end
                    else
                    begin
                        i_next = i_reg + tlg_pkg::SIDE_W'(1);
                    end
                end
                else
                begin
                    j_next = j_reg + tlg_pkg::SIDE_W'(1);
                    c_next = tlg_pkg::col_inc(c_reg, nc);
                end
            end
            S_STEP:
            begin
                // Nine neighborhood reads, then one write of the new state.
                if (k_reg != 4'd9)
                begin
                    cur_req.raddr = tlg_pkg::cell_addr(nb_r, nb_c);
                    k_next        = k_reg + 4'd1;
                end
                if (k_reg == 4'd5)
                begin
                    center_next = cur_rdata;
                end
                else if (k_reg != 4'd0 && k_reg != 4'd9)
                begin
                    sum_next = total;
                end
                if (k_reg == 4'd9)
                begin
                    nxt_req.we    = 1'b1;
                    nxt_req.waddr = tlg_pkg::cell_addr(r_reg, c_reg);
                    nxt_req.wdata = (total == 4'd3) || (center_reg && total == 4'd2);
                    k_next        = '0;
                    sum_next      = '0;
                    if (last_col)
                    begin
                        c_next = '0;
                        if (last_row)
                        begin
                            r_next     = '0;
                            pend_next  = 1'b0;
                            state_next = S_COPY;
                        end
                        else
                        begin
                            r_next = r_reg + tlg_pkg::ROW_W'(1);
                        end
                    end
                    else
                    begin
                        c_next = c_reg + tlg_pkg::COL_W'(1);
                    end
                end
            end
            S_COPY:
            begin
                // Read the scratch grid one cell ahead of the write-back.
                nxt_req.raddr = tlg_pkg::cell_addr(r_reg, c_reg);
                if (pend_reg)
                begin
                    cur_req.we    = 1'b1;
                    cur_req.waddr = paddr_reg;
                    cur_req.wdata = nxt_rdata;
                end
                paddr_next = tlg_pkg::cell_addr(r_reg, c_reg);
                pend_next  = 1'b1;
                if (last_col)
                begin
                    c_next = '0;
                    if (last_row)
                    begin
                        state_next = S_COPY_LAST;
                    end
                    else
                    begin
                        r_next = r_reg + tlg_pkg::ROW_W'(1);
                    end
                end
                else
                begin
                    c_next = c_reg + tlg_pkg::COL_W'(1);
                end
            end
            S_COPY_LAST:
            begin
                cur_req.we    = 1'b1;
                cur_req.waddr = paddr_reg;
                cur_req.wdata = nxt_rdata;
                pend_next     = 1'b0;
                res_done_next = 1'b1;
                state_next    = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next  = 1'b1;
                    read_value_next = res_rv_reg;
                    op_done_next    = res_done_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            addr_reg      <= '0;
            pend_reg      <= 1'b0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            addr_reg      <= addr_next;
            pend_reg      <= pend_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        r_reg          <= r_next;
        c_reg          <= c_next;
        c0_reg         <= c0_next;
        v_reg          <= v_next;
        rad_reg        <= rad_next;
        cnt_reg        <= cnt_next;
        i_reg          <= i_next;
        j_reg          <= j_next;
        paddr_reg      <= paddr_next;
        sum_reg        <= sum_next;
        center_reg     <= center_next;
        res_rv_reg     <= res_rv_next;
        res_done_reg   <= res_done_next;
        read_value_reg <= read_value_next;
        op_done_reg    <= op_done_next;
    end

    assign out_valid  = out_valid_reg;
    assign read_value = read_value_reg;
    assign op_done    = op_done_reg;

endmodule

/* rtl/core/tlg_checker.sv */
// ----------------------------------------------------------------------------
// tlg_checker
// Port-level checks of the life grid engine, bound to the top level.
// ----------------------------------------------------------------------------
module tlg_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_stall,
    input logic out_valid,
    input logic out_stall,
    input logic read_value,
    input logic op_done
);

    // A held result stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // A cell value is only reported by a completed operation.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && read_value |-> op_done)
        else $error("read value without completion");

    // One request at a time: the block is busy right after taking one.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("request taken while busy");

    // Reset empties the result register.
    assert property (@(posedge clk)
        !rst_n |=> !out_valid)
        else $error("result valid during reset");

endmodule

bind toroidal_life_grid_engine tlg_checker u_tlg_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .read_value (read_value),
    .op_done    (op_done)
);
